[rtl/core/fgl_pkg.sv]
`timescale 1ns / 1ps

package fgl_pkg;

	localparam int MAX_PEOPLE = 1024;
	localparam int IDX_W      = $clog2(MAX_PEOPLE);
	localparam int LABEL_W    = 12;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [LABEL_W-1:0] label_t;
	typedef logic signed [1:0]  seg_t;

	localparam label_t LABEL_MAX = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_RD2,
		ST_EX
	} state_t;

	typedef struct packed {
		logic stall;
		logic accept;
		logic rd_a_en;
		logic rd_b_en;
		logic ex_fire;
		logic mem_we;
	} ctrl_t;

	// saturating step of the founder label counter
	function automatic label_t sat_inc(input label_t v);
		sat_inc = (v == LABEL_MAX) ? v : label_t'(v + label_t'(1));
	endfunction

endpackage

[rtl/core/founder_gene_label_pass_unit.sv]
`timescale 1ns / 1ps
// An accepted item is read (a second read when both inherited labels come from the
// same label table, second read on that port), then executed: labels are written and
// the output register loaded once the output is free, and the next item is taken then;
// the pace is set by the read-then-write sequence on the label memories, each with one
// person port and one parent port. Reset: arst_n asynchronous, active low; then a
// clearing pass over all MAX_PEOPLE (1024) entries zeroes both tables, item_stall high.
module founder_gene_label_pass_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  fgl_pkg::idx_t    person,
	input  fgl_pkg::seg_t    pat_segregation,
	input  fgl_pkg::seg_t    mat_segregation,
	input  fgl_pkg::idx_t    sire_index,
	input  fgl_pkg::idx_t    dam_index,
	input  logic             first_in_group,
	input  logic             singleton_group,
	input  logic             watch_change,
	output logic             result_valid,
	input  logic             result_stall,
	output fgl_pkg::idx_t    person_out,
	output fgl_pkg::label_t  pat_label,
	output fgl_pkg::label_t  mat_label,
	output logic             changed_so_far
);
	import fgl_pkg::*;

	// Sequencer
	state_t state_q, state_d;
	ctrl_t  ctrl;
	logic   out_free;
	logic   conflict;
	idx_t   clr_q;
	logic   clr_last;

	// Item held for the duration of its work
	idx_t   person_q;
	seg_t   pseg_q;
	seg_t   mseg_q;
	idx_t   sire_q;
	idx_t   dam_q;
	logic   first_q;
	logic   single_q;
	logic   watch_q;

	// Group state
	label_t cnt_q;
	logic   chg_q;

	// Label memories: port A reads the member's own entry, port B a parent's
	label_t pat_mem [MAX_PEOPLE];
	label_t mat_mem [MAX_PEOPLE];
	label_t pat_a_rd, mat_a_rd, pat_b_rd, mat_b_rd;
	idx_t   pat_b_addr, mat_b_addr, wr_addr;
	label_t pat_wr, mat_wr;
	label_t src_p_q;

	// Label computation
	label_t cnt_base, cnt_mid, cnt_new;
	label_t src_p, src_m_mem, src_m;
	label_t new_p, new_m;
	logic   chg_base, chg_new;

	// Output register
	logic   out_valid_q;
	idx_t   person_out_q;
	label_t pat_label_q, mat_label_q;
	logic   changed_q;

	assign out_free = !out_valid_q || !result_stall;
	assign clr_last = (clr_q == idx_t'(MAX_PEOPLE - 1));

	// Both inherited labels want port B of the same table: an extra read state, RD2.
	assign conflict = !single_q && !pseg_q[1] && !mseg_q[1] && (pseg_q[0] == mseg_q[0]);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (item_valid) state_d = ST_RD;
			end
			ST_RD: begin
				state_d = conflict ? ST_RD2 : ST_EX;
			end
			ST_RD2: begin
				state_d = ST_EX;
			end
			ST_EX: begin
				if (out_free) state_d = item_valid ? ST_RD : ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ctrl.stall  = 1'b1;
				ctrl.mem_we = 1'b1;
			end
			ST_IDLE: begin
				ctrl.stall = 1'b0;
			end
			ST_RD: begin
				ctrl.stall   = 1'b1;
				ctrl.rd_a_en = 1'b1;
				ctrl.rd_b_en = 1'b1;
			end
			ST_RD2: begin
				ctrl.stall   = 1'b1;
				ctrl.rd_b_en = 1'b1;
			end
			ST_EX: begin
				ctrl.stall   = !out_free;
				ctrl.ex_fire = out_free;
				ctrl.mem_we  = out_free;
			end
			default: ctrl.stall = 1'b1;
		endcase
		ctrl.accept = item_valid && !ctrl.stall;
	end

	assign item_stall = ctrl.stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
			chg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= idx_t'(clr_q + idx_t'(1));
			if (ctrl.ex_fire) begin
				cnt_q <= cnt_new;
				chg_q <= chg_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			person_q <= person;
			pseg_q   <= pat_segregation;
			mseg_q   <= mat_segregation;
			sire_q   <= sire_index;
			dam_q    <= dam_index;
			first_q  <= first_in_group;
			single_q <= singleton_group;
			watch_q  <= watch_change;
		end
	end

	// First read routes sire to the paternal source table; second read always dam.
	always_comb begin
		if (state_q == ST_RD2) begin
			pat_b_addr = dam_q;
			mat_b_addr = dam_q;
		end else begin
			pat_b_addr = (!pseg_q[1] && !pseg_q[0]) ? sire_q : dam_q;
			mat_b_addr = (!pseg_q[1] &&  pseg_q[0]) ? sire_q : dam_q;
		end
	end

	assign wr_addr = (state_q == ST_CLEAR) ? clr_q : person_q;
	assign pat_wr  = (state_q == ST_CLEAR) ? '0 : new_p;
	assign mat_wr  = (state_q == ST_CLEAR) ? '0 : new_m;

	always_ff @(posedge clk) begin
		if (ctrl.mem_we) pat_mem[wr_addr] <= pat_wr;
		if (ctrl.rd_a_en) pat_a_rd <= pat_mem[person_q];
		if (ctrl.rd_b_en) pat_b_rd <= pat_mem[pat_b_addr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.mem_we) mat_mem[wr_addr] <= mat_wr;
		if (ctrl.rd_a_en) mat_a_rd <= mat_mem[person_q];
		if (ctrl.rd_b_en) mat_b_rd <= mat_mem[mat_b_addr];
	end

	// Keep the paternal source across the second read.
	always_ff @(posedge clk) begin
		if (state_q == ST_RD2) src_p_q <= pseg_q[0] ? mat_b_rd : pat_b_rd;
	end

	always_comb begin
		cnt_base  = first_q ? '0 : cnt_q;
		chg_base  = first_q ? 1'b0 : chg_q;
		src_p     = conflict ? src_p_q : (pseg_q[0] ? mat_b_rd : pat_b_rd);
		src_m_mem = mseg_q[0] ? mat_b_rd : pat_b_rd;
		if (single_q) begin
			// maternal first, then paternal
			new_m   = sat_inc(cnt_base);
			new_p   = sat_inc(new_m);
			cnt_mid = new_m;
			cnt_new = new_p;
			src_m   = src_m_mem;
		end else begin
			new_p   = pseg_q[1] ? sat_inc(cnt_base) : src_p;
			cnt_mid = pseg_q[1] ? new_p : cnt_base;
			// dam equal to the member, paternal code: sees the label just written
			src_m   = (!mseg_q[0] && (dam_q == person_q)) ? new_p : src_m_mem;
			new_m   = mseg_q[1] ? sat_inc(cnt_mid) : src_m;
			cnt_new = mseg_q[1] ? new_m : cnt_mid;
		end
		chg_new = chg_base || (watch_q && ((new_p != pat_a_rd) || (new_m != mat_a_rd)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.ex_fire) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ex_fire) begin
			person_out_q <= person_q;
			pat_label_q  <= new_p;
			mat_label_q  <= new_m;
			changed_q    <= chg_new;
		end
	end

	assign result_valid   = out_valid_q;
	assign person_out     = person_out_q;
	assign pat_label      = pat_label_q;
	assign mat_label      = mat_label_q;
	assign changed_so_far = changed_q;

	// An accepted item always starts with the person/parent read.
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.accept |=> (state_q == ST_RD))
		else $error("accepted item did not enter the read cycle");

	// A second read only follows a first read.
	a_rd2_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD2) |-> ($past(state_q) == ST_RD))
		else $error("second read without first read");

	// Finishing an item presents a result on the next cycle.
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ex_fire |=> result_valid)
		else $error("finished item produced no result");

	// No item is taken while the tables are being cleared.
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) && !clr_last |=> item_stall)
		else $error("item port open during clearing pass");

endmodule

[tb/founder_gene_label_pass_checker.sv]
`timescale 1ns / 1ps

module founder_gene_label_pass_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  fgl_pkg::idx_t    person,
	input  fgl_pkg::seg_t    pat_segregation,
	input  fgl_pkg::seg_t    mat_segregation,
	input  fgl_pkg::idx_t    sire_index,
	input  fgl_pkg::idx_t    dam_index,
	input  logic             first_in_group,
	input  logic             singleton_group,
	input  logic             watch_change,
	input  logic             result_valid,
	input  logic             result_stall,
	input  fgl_pkg::idx_t    person_out,
	input  fgl_pkg::label_t  pat_label,
	input  fgl_pkg::label_t  mat_label,
	input  logic             changed_so_far,
	output int               mismatches,
	output int               waiting
);
	import fgl_pkg::*;

	typedef struct packed {
		idx_t   person;
		label_t pat;
		label_t mat;
		logic   changed;
	} labelled_t;

	label_t    pat_tab [MAX_PEOPLE];
	label_t    mat_tab [MAX_PEOPLE];
	label_t    founder_count;
	logic      change_flag;
	labelled_t pending_labels [$];
	labelled_t due;
	int        err_count     = 0;
	int        pending_count = 0;

	assign mismatches = err_count;
	assign waiting    = pending_count;

	// counter stops at all ones
	function automatic label_t next_founder_label();
		if (founder_count != '1)
			founder_count = founder_count + label_t'(1);
		return founder_count;
	endfunction

	// negative code: fresh label; else bit 0 picks parent's paternal/maternal entry
	function automatic label_t inherited_label(input seg_t code, input idx_t parent);
		if (code[1])
			return next_founder_label();
		return code[0] ? mat_tab[parent] : pat_tab[parent];
	endfunction

	function automatic labelled_t label_member(input idx_t p, input seg_t ps, input seg_t ms,
			input idx_t s, input idx_t d, input logic first, input logic single,
			input logic watch);
		labelled_t r;
		label_t    old_p;
		label_t    old_m;
		if (first) begin
			founder_count = '0;
			change_flag   = 1'b0;
		end
		old_p = pat_tab[p];
		old_m = mat_tab[p];
		r.person = p;
		if (single) begin
			r.mat = next_founder_label();
			r.pat = next_founder_label();
			mat_tab[p] = r.mat;
			pat_tab[p] = r.pat;
		end else begin
			// paternal write lands before the maternal source is read
			r.pat = inherited_label(ps, s);
			pat_tab[p] = r.pat;
			r.mat = inherited_label(ms, d);
			mat_tab[p] = r.mat;
		end
		if (watch && !change_flag && (r.pat != old_p || r.mat != old_m))
			change_flag = 1'b1;
		r.changed = change_flag;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PEOPLE; i++) begin
				pat_tab[i] = '0;
				mat_tab[i] = '0;
			end
			founder_count = '0;
			change_flag   = 1'b0;
			pending_labels.delete();
			pending_count = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pending_labels.size() == 0) begin
					$error("result for person %0d with no labelled member waiting", person_out);
					err_count++;
				end else begin
					due = pending_labels.pop_front();
					if (person_out !== due.person) begin
						$error("person_out: expected %0d, got %0d", due.person, person_out);
						err_count++;
					end
					if (pat_label !== due.pat) begin
						$error("pat_label: expected %0d, got %0d", due.pat, pat_label);
						err_count++;
					end
					if (mat_label !== due.mat) begin
						$error("mat_label: expected %0d, got %0d", due.mat, mat_label);
						err_count++;
					end
					if (changed_so_far !== due.changed) begin
						$error("changed_so_far: expected %0d, got %0d", due.changed,
							changed_so_far);
						err_count++;
					end
				end
			end
			if (item_valid && !item_stall)
				pending_labels.push_back(label_member(person, pat_segregation,
					mat_segregation, sire_index, dam_index, first_in_group,
					singleton_group, watch_change));
			pending_count = pending_labels.size();
		end
	end

endmodule

[tb/founder_gene_label_pass_unit_test.sv]
`timescale 1ns / 1ps

module founder_gene_label_pass_unit_test;
	import fgl_pkg::*;

	localparam int RANDOM_ITEMS   = 1100;
	localparam int QUIET_FROM     = 980;   // last stretch of the random part: no idling
	localparam int SAT_ITEMS      = 2060;  // two fresh labels each, enough to pin the counter
	localparam int MAX_GROUP      = 12;

	logic    clk             = 1'b0;
	logic    arst_n          = 1'b0;
	logic    item_valid      = 1'b0;
	logic    item_stall;
	idx_t    person          = '0;
	seg_t    pat_segregation = '0;
	seg_t    mat_segregation = '0;
	idx_t    sire_index      = '0;
	idx_t    dam_index       = '0;
	logic    first_in_group  = 1'b0;
	logic    singleton_group = 1'b0;
	logic    watch_change    = 1'b0;
	logic    result_valid;
	logic    result_stall    = 1'b0;
	idx_t    person_out;
	label_t  pat_label;
	label_t  mat_label;
	logic    changed_so_far;

	int      mismatches;
	int      waiting;

	// idling knobs: odds of 1 in N per item / per cycle, 0 = no idling at all
	int      gap_odds   = 4;
	int      stall_odds = 6;
	bit      quiet      = 1'b0;
	int      stall_left = 0;
	int      random_sent = 0;

	// last well-formed pedigree, kept so it can be replayed with watching on
	idx_t    g_person [MAX_GROUP];
	seg_t    g_ps     [MAX_GROUP];
	seg_t    g_ms     [MAX_GROUP];
	idx_t    g_sire   [MAX_GROUP];
	idx_t    g_dam    [MAX_GROUP];
	int      g_len;
	int      g_founders;

	always #1 clk = ~clk;

	founder_gene_label_pass_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.person          (person),
		.pat_segregation (pat_segregation),
		.mat_segregation (mat_segregation),
		.sire_index      (sire_index),
		.dam_index       (dam_index),
		.first_in_group  (first_in_group),
		.singleton_group (singleton_group),
		.watch_change    (watch_change),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.person_out      (person_out),
		.pat_label       (pat_label),
		.mat_label       (mat_label),
		.changed_so_far  (changed_so_far)
	);

	founder_gene_label_pass_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.person          (person),
		.pat_segregation (pat_segregation),
		.mat_segregation (mat_segregation),
		.sire_index      (sire_index),
		.dam_index       (dam_index),
		.first_in_group  (first_in_group),
		.singleton_group (singleton_group),
		.watch_change    (watch_change),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.person_out      (person_out),
		.pat_label       (pat_label),
		.mat_label       (mat_label),
		.changed_so_far  (changed_so_far),
		.mismatches      (mismatches),
		.waiting         (waiting)
	);

	// Receiver back-pressure: bursts of result_stall at random, none once quiet.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left   <= stall_left - 1;
		end else if (!quiet && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
			result_stall <= 1'b1;
			stall_left   <= $urandom_range(0, 12);
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Present one member at the current falling edge and hold it until taken.
	// Returns at a falling edge; an optional gap follows with valid low.
	task automatic push_member(input idx_t p, input seg_t ps, input seg_t ms, input idx_t s,
			input idx_t d, input logic first, input logic single, input logic watch);
		item_valid      <= 1'b1;
		person          <= p;
		pat_segregation <= ps;
		mat_segregation <= ms;
		sire_index      <= s;
		dam_index       <= d;
		first_in_group  <= first;
		singleton_group <= single;
		watch_change    <= watch;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
		if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	// Hold off the sender until every labelled member has come out.
	// Always waits for a falling edge so valid is never dropped and raised in one step.
	task automatic drain_labels();
		item_valid <= 1'b0;
		do @(negedge clk); while (waiting != 0);
	endtask

	function automatic seg_t founder_code();
		return ($urandom_range(0, 3) == 0) ? seg_t'(-2) : seg_t'(-1);
	endfunction

	// child side: mostly an inherited gene, now and then a founder haplotype
	function automatic seg_t child_code();
		return ($urandom_range(0, 7) == 0) ? founder_code() : seg_t'($urandom_range(0, 1));
	endfunction

	// Build a fresh pedigree: founders first, then children of earlier members.
	task automatic build_pedigree();
		idx_t base;
		base       = idx_t'($urandom);
		g_len      = $urandom_range(2, MAX_GROUP);
		g_founders = $urandom_range(1, (g_len < 3) ? g_len : 3);
		for (int k = 0; k < g_len; k++) begin
			g_person[k] = base + idx_t'(k);
			if (k < g_founders) begin
				g_ps[k]   = founder_code();
				g_ms[k]   = founder_code();
				g_sire[k] = idx_t'($urandom);
				g_dam[k]  = idx_t'($urandom);
			end else begin
				g_ps[k]   = child_code();
				g_ms[k]   = child_code();
				g_sire[k] = g_person[$urandom_range(0, k - 1)];
				g_dam[k]  = g_person[$urandom_range(0, k - 1)];
			end
		end
	endtask

	// Send the stored pedigree; a replay watches most members, so the labels
	// match the old ones unless one segregation bit was flipped.
	task automatic send_pedigree(input bit replay);
		for (int k = 0; k < g_len; k++) begin
			push_member(g_person[k], g_ps[k], g_ms[k], g_sire[k], g_dam[k], k == 0, 1'b0,
				replay ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0));
			random_sent++;
			if (random_sent >= QUIET_FROM)
				quiet = 1'b1;
		end
	endtask

	initial begin
		int m;
		int kind;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		// the block clears its tables after reset with item_stall high;
		// the first push simply waits that out

		// ---- directed part ----
		// two founders, then children copying each gene choice
		push_member(10'd0,    seg_t'(-1), seg_t'(-1), 10'd0,    10'd0,    1'b1, 1'b0, 1'b0);
		push_member(10'd1023, seg_t'(-2), seg_t'(-2), 10'd1023, 10'd1023, 1'b0, 1'b0, 1'b0);
		push_member(10'd2,    seg_t'(0),  seg_t'(1),  10'd0,    10'd1023, 1'b0, 1'b0, 1'b0);
		push_member(10'd3,    seg_t'(1),  seg_t'(0),  10'd1023, 10'd0,    1'b0, 1'b0, 1'b0);
		// dam is the member itself: maternal copy sees the paternal label just written
		push_member(10'd5,    seg_t'(-1), seg_t'(0),  10'd5,    10'd5,    1'b0, 1'b0, 1'b0);
		// sire and dam are the member: maternal entries read before they are written
		push_member(10'd6,    seg_t'(1),  seg_t'(1),  10'd6,    10'd6,    1'b0, 1'b0, 1'b0);
		push_member(10'd7,    seg_t'(0),  seg_t'(1),  10'd7,    10'd7,    1'b0, 1'b0, 1'b0);
		// watched member with identical labels: no change
		push_member(10'd2,    seg_t'(0),  seg_t'(1),  10'd0,    10'd1023, 1'b0, 1'b0, 1'b1);
		// watched member with a different paternal label: change flag sets
		push_member(10'd3,    seg_t'(0),  seg_t'(0),  10'd1023, 10'd0,    1'b0, 1'b0, 1'b1);
		// watched after a change: flag stays set whatever the labels
		push_member(10'd2,    seg_t'(1),  seg_t'(1),  10'd0,    10'd1023, 1'b0, 1'b0, 1'b1);
		drain_labels();
		// singleton group, watched on its first member
		push_member(10'd0,    seg_t'(0),  seg_t'(0),  10'd0,    10'd0,    1'b1, 1'b1, 1'b1);
		push_member(10'd1023, seg_t'(-1), seg_t'(1),  10'd0,    10'd0,    1'b0, 1'b1, 1'b0);
		// new group mixing an inherited and a fresh label
		push_member(10'd4,    seg_t'(1),  seg_t'(-2), 10'd1023, 10'd1023, 1'b1, 1'b0, 1'b1);
		push_member(10'd8,    seg_t'(1),  seg_t'(1),  10'd1023, 10'd1023, 1'b0, 1'b0, 1'b0);
		push_member(10'd9,    seg_t'(-2), seg_t'(0),  10'd0,    10'd8,    1'b0, 1'b0, 1'b1);

		// ---- counter saturation: one long singleton group ----
		push_member(idx_t'($urandom), seg_t'($urandom_range(0, 3)), seg_t'($urandom_range(0, 3)),
			idx_t'($urandom), idx_t'($urandom), 1'b1, 1'b1, 1'b0);
		for (int i = 0; i < SAT_ITEMS; i++)
			push_member(idx_t'($urandom), seg_t'($urandom_range(0, 3)),
				seg_t'($urandom_range(0, 3)), idx_t'($urandom), idx_t'($urandom),
				1'b0, 1'b1, 1'($urandom_range(0, 1)));
		// pinned counter on an ordinary founder and a child of it, same group
		push_member(10'd100,  seg_t'(-1), seg_t'(-2), 10'd0,    10'd0,    1'b0, 1'b0, 1'b1);
		push_member(10'd101,  seg_t'(0),  seg_t'(1),  10'd100,  10'd100,  1'b0, 1'b0, 1'b1);

		// ---- random part ----
		while (random_sent < RANDOM_ITEMS) begin
			if (!quiet) begin
				case ($urandom_range(0, 3))
					0: gap_odds = 0;
					1: gap_odds = 2;
					default: gap_odds = 5;
				endcase
				case ($urandom_range(0, 3))
					0: stall_odds = 0;
					1: stall_odds = 3;
					default: stall_odds = 8;
				endcase
			end
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				build_pedigree();
				send_pedigree(1'b0);
				if ($urandom_range(0, 1) == 0) begin
					// replay, half the time with one inherited bit flipped
					if ($urandom_range(0, 1) == 0 && g_len > g_founders) begin
						m = $urandom_range(g_founders, g_len - 1);
						if (!g_ps[m][1])
							g_ps[m] = g_ps[m] ^ seg_t'(1);
					end
					send_pedigree(1'b1);
				end
			end else if (kind < 17) begin
				// singleton group of unrelated members
				m = $urandom_range(1, 6);
				for (int k = 0; k < m; k++) begin
					push_member(idx_t'($urandom), seg_t'($urandom_range(0, 3)),
						seg_t'($urandom_range(0, 3)), idx_t'($urandom), idx_t'($urandom),
						k == 0, 1'b1, 1'($urandom_range(0, 1)));
					random_sent++;
				end
			end else begin
				// noise: arbitrary fields, groups broken at random
				push_member(idx_t'($urandom), seg_t'($urandom_range(0, 3)),
					seg_t'($urandom_range(0, 3)), idx_t'($urandom), idx_t'($urandom),
					$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
					1'($urandom_range(0, 1)));
				random_sent++;
			end
			if (random_sent >= QUIET_FROM)
				quiet = 1'b1;
			// one more full drain mid-run
			if (random_sent >= RANDOM_ITEMS / 2 && random_sent < RANDOM_ITEMS / 2 + MAX_GROUP)
				drain_labels();
		end

		// ---- wind down: everything out, then a few more cycles for strays ----
		drain_labels();
		repeat (12) @(negedge clk);
		if (waiting != 0)
			$error("%0d labelled members never came out", waiting);
		if (mismatches == 0 && waiting == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog well past the slowest legal run
	initial begin
		#1500000;
		$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/fgl_pkg.sv
rtl/core/founder_gene_label_pass_unit.sv
tb/founder_gene_label_pass_checker.sv
tb/founder_gene_label_pass_unit_test.sv
